@@ src/csfs_pkg.sv @@
// Shared constants and types of the chi-square feature score unit.
`timescale 1ns / 1ps
`default_nettype none
package csfs_pkg;
  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CNT_W          = 32;
  localparam int SCORE_W        = 48;

  typedef struct packed {
    logic vld;
    logic deg;
    logic inv;
  } csfs_ctl_t;
endpackage
`default_nettype wire

@@ src/csfs_prep.sv @@
// Seven-stage front end: table checks, numerator N*(AN-CG)^2 and denominator C*G*(N-C)*(N-G).
`timescale 1ns / 1ps
`default_nettype none
module csfs_prep #(
  parameter int W = csfs_pkg::COUNT_BITS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        adv,
  input  wire                        in_vld,
  input  wire [csfs_pkg::CNT_W-1:0]  in_a,
  input  wire [csfs_pkg::CNT_W-1:0]  in_g,
  input  wire [csfs_pkg::CNT_W-1:0]  in_c,
  input  wire [csfs_pkg::CNT_W-1:0]  in_n,
  output csfs_pkg::csfs_ctl_t        ctl_o,
  output logic [5*W-1:0]             num_o,
  output logic [4*W-1:0]             den_o
);
  logic [W+csfs_pkg::CNT_W-1:0] ext_a, ext_g, ext_c, ext_n;
  logic [W-1:0] a, g, c, n;
  logic [W:0]   sum_cg, sum_na;
  logic         deg, inv;

  csfs_pkg::csfs_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r, ctl7_r;
  logic [W-1:0]   a1_r, g1_r, c1_r, n1_r;
  logic [2*W-1:0] x2_r, y2_r;
  logic [W-1:0]   nc2_r, ng2_r, n2_r;
  logic [2*W-1:0] d3_r, cg3_r, p3_r;
  logic [W-1:0]   n3_r, n4_r, n5_r;
  logic [2*W-1:0] hh4_r, hl4_r, ll4_r, ehfh4_r, ehfl4_r, elfh4_r, elfl4_r;
  logic [4*W-1:0] sq5_r, den5_r, den6_r, den7_r;
  logic [2*W-1:0] pp0_6_r, pp1_6_r, pp2_6_r, pp3_6_r;
  logic [5*W-1:0] num7_r;
  logic [2*W:0]   mid_sum;

  assign ext_a  = {{W{1'b0}}, in_a};
  assign ext_g  = {{W{1'b0}}, in_g};
  assign ext_c  = {{W{1'b0}}, in_c};
  assign ext_n  = {{W{1'b0}}, in_n};
  assign a      = ext_a[W-1:0];
  assign g      = ext_g[W-1:0];
  assign c      = ext_c[W-1:0];
  assign n      = ext_n[W-1:0];
  assign sum_cg = {1'b0, c} + {1'b0, g};
  assign sum_na = {1'b0, n} + {1'b0, a};
  assign deg    = (c == '0) || (g == '0) || (c == n) || (g == n);
  assign inv    = !deg && ((c > n) || (g > n) || (a > c) || (a > g) || (sum_cg > sum_na));
  assign mid_sum = {1'b0, ehfl4_r} + {1'b0, elfh4_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
      ctl7_r <= '0;
    end else if (adv) begin
      ctl1_r <= '{vld: in_vld, deg: deg, inv: inv};
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
      ctl7_r <= ctl6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r    <= a;
      g1_r    <= g;
      c1_r    <= c;
      n1_r    <= n;
      x2_r    <= a1_r * n1_r;
      y2_r    <= c1_r * g1_r;
      nc2_r   <= n1_r - c1_r;
      ng2_r   <= n1_r - g1_r;
      n2_r    <= n1_r;
      d3_r    <= (x2_r >= y2_r) ? (x2_r - y2_r) : (y2_r - x2_r);
      cg3_r   <= y2_r;
      p3_r    <= nc2_r * ng2_r;
      n3_r    <= n2_r;
      hh4_r   <= d3_r[2*W-1:W] * d3_r[2*W-1:W];
      hl4_r   <= d3_r[2*W-1:W] * d3_r[W-1:0];
      ll4_r   <= d3_r[W-1:0] * d3_r[W-1:0];
      ehfh4_r <= cg3_r[2*W-1:W] * p3_r[2*W-1:W];
      ehfl4_r <= cg3_r[2*W-1:W] * p3_r[W-1:0];
      elfh4_r <= cg3_r[W-1:0] * p3_r[2*W-1:W];
      elfl4_r <= cg3_r[W-1:0] * p3_r[W-1:0];
      n4_r    <= n3_r;
      sq5_r   <= {hh4_r, ll4_r} + {{(W-1){1'b0}}, hl4_r, {(W+1){1'b0}}};
      den5_r  <= {ehfh4_r, elfl4_r} + {{(W-1){1'b0}}, mid_sum, {W{1'b0}}};
      n5_r    <= n4_r;
      pp0_6_r <= sq5_r[W-1:0] * n5_r;
      pp1_6_r <= sq5_r[2*W-1:W] * n5_r;
      pp2_6_r <= sq5_r[3*W-1:2*W] * n5_r;
      pp3_6_r <= sq5_r[4*W-1:3*W] * n5_r;
      den6_r  <= den5_r;
      num7_r  <= {{(3*W){1'b0}}, pp0_6_r}
               + {{(2*W){1'b0}}, pp1_6_r, {W{1'b0}}}
               + {{W{1'b0}}, pp2_6_r, {(2*W){1'b0}}}
               + {pp3_6_r, {(3*W){1'b0}}};
      den7_r  <= den6_r;
    end
  end

  assign ctl_o = ctl7_r;
  assign num_o = num7_r;
  assign den_o = den7_r;
endmodule
`default_nettype wire

@@ src/csfs_div_stage.sv @@
// One registered step of the pipelined restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module csfs_div_stage #(
  parameter int W  = csfs_pkg::COUNT_BITS_DEF,
  parameter int QW = csfs_pkg::COUNT_BITS_DEF + csfs_pkg::FRAC_BITS_DEF + 1
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   adv,
  input  wire csfs_pkg::csfs_ctl_t ctl_i,
  input  wire [4*W-1:0]         rem_i,
  input  wire [QW-1:0]          lo_i,
  input  wire [QW-1:0]          quo_i,
  input  wire [4*W-1:0]         den_i,
  output csfs_pkg::csfs_ctl_t   ctl_o,
  output logic [4*W-1:0]        rem_o,
  output logic [QW-1:0]         lo_o,
  output logic [QW-1:0]         quo_o,
  output logic [4*W-1:0]        den_o
);
  logic [4*W:0] trial, diff;
  logic         ge;
  csfs_pkg::csfs_ctl_t ctl_r;
  logic [4*W-1:0] rem_r, den_r;
  logic [QW-1:0]  lo_r, quo_r;

  assign trial = {rem_i, lo_i[QW-1]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = trial >= {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= ge ? diff[4*W-1:0] : trial[4*W-1:0];
      lo_r  <= {lo_i[QW-2:0], 1'b0};
      quo_r <= {quo_i[QW-2:0], ge};
      den_r <= den_i;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign lo_o  = lo_r;
  assign quo_o = quo_r;
  assign den_o = den_r;
endmodule
`default_nettype wire

@@ src/chi_square_feature_score_unit.sv @@
// Top level of the chi-square feature score unit: front end, divider chain and output register.
//  channel  direction  ports
//  in       input      in_valid, in_ready, in_joint_count, in_class_count, in_feature_count
//  out      output     out_valid, out_ready, out_score, out_degenerate, out_invalid
//  cfg      input      cfg_valid, cfg_ready, cfg_total_samples
// One transaction enters per cycle while the output is not stalled; a result passes through seven
// front-end stages, one divider stage per quotient bit and the output register.
// Synchronous active-low reset empties the pipeline and clears total_samples.
// When a result waits at the output the whole pipeline holds, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module chi_square_feature_score_unit #(
  parameter int COUNT_BITS = csfs_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = csfs_pkg::FRAC_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [csfs_pkg::CNT_W-1:0]     in_joint_count,
  input  wire [csfs_pkg::CNT_W-1:0]     in_class_count,
  input  wire [csfs_pkg::CNT_W-1:0]     in_feature_count,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [csfs_pkg::SCORE_W-1:0]  out_score,
  output logic                          out_degenerate,
  output logic                          out_invalid,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [csfs_pkg::CNT_W-1:0]     cfg_total_samples
);
  localparam int W  = COUNT_BITS;
  localparam int QW = COUNT_BITS + FRAC_BITS + 1;
  localparam int SW = csfs_pkg::SCORE_W;

  logic adv;
  logic [csfs_pkg::CNT_W-1:0] total_r;
  csfs_pkg::csfs_ctl_t pre_ctl;
  logic [5*W-1:0] pre_num;
  logic [4*W-1:0] pre_den;

  csfs_pkg::csfs_ctl_t ctl_s [QW+1];
  logic [4*W-1:0] rem_s [QW+1];
  logic [QW-1:0]  lo_s  [QW+1];
  logic [QW-1:0]  quo_s [QW+1];
  logic [4*W-1:0] den_s [QW+1];

  logic [QW:0]      qp1;
  logic [QW+SW-1:0] score_ext;
  logic             out_valid_r, out_deg_r, out_inv_r;
  logic [SW-1:0]    out_score_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cfg_valid) begin
      total_r <= cfg_total_samples;
    end
  end

  csfs_prep #(.W(W)) u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_valid),
    .in_a   (in_joint_count),
    .in_g   (in_class_count),
    .in_c   (in_feature_count),
    .in_n   (total_r),
    .ctl_o  (pre_ctl),
    .num_o  (pre_num),
    .den_o  (pre_den)
  );

  assign ctl_s[0] = pre_ctl;
  assign rem_s[0] = pre_num[5*W-1:W];
  assign lo_s[0]  = {pre_num[W-1:0], {(FRAC_BITS+1){1'b0}}};
  assign quo_s[0] = '0;
  assign den_s[0] = pre_den;

  for (genvar i = 0; i < QW; i++) begin : g_div
    csfs_div_stage #(.W(W), .QW(QW)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (ctl_s[i]),
      .rem_i (rem_s[i]),
      .lo_i  (lo_s[i]),
      .quo_i (quo_s[i]),
      .den_i (den_s[i]),
      .ctl_o (ctl_s[i+1]),
      .rem_o (rem_s[i+1]),
      .lo_o  (lo_s[i+1]),
      .quo_o (quo_s[i+1]),
      .den_o (den_s[i+1])
    );
  end

  assign qp1       = {1'b0, quo_s[QW]} + {{QW{1'b0}}, 1'b1};
  assign score_ext = {{SW{1'b0}}, qp1[QW:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_s[QW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_deg_r   <= ctl_s[QW].deg;
      out_inv_r   <= ctl_s[QW].inv;
      out_score_r <= (ctl_s[QW].deg || ctl_s[QW].inv) ? '0 : score_ext[SW-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_score      = out_score_r;
  assign out_degenerate = out_deg_r;
  assign out_invalid    = out_inv_r;
endmodule
`default_nettype wire

@@ src/csfs_checker.sv @@
// Port-level assertions for the chi-square feature score unit and their bind.
`timescale 1ns / 1ps
`default_nettype none
module csfs_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [csfs_pkg::SCORE_W-1:0]  out_score,
  input wire                          out_degenerate,
  input wire                          out_invalid
);
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_degenerate && out_invalid))
    else $error("degenerate and invalid both set");

  a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_degenerate || out_invalid)) |-> (out_score == '0))
    else $error("flagged transaction carries a nonzero score");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while the output is free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_score)))
    else $error("output transaction changed while stalled");
endmodule

bind chi_square_feature_score_unit csfs_checker u_csfs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_score      (out_score),
  .out_degenerate (out_degenerate),
  .out_invalid    (out_invalid)
);
`default_nettype wire
